FILE: hw/rtl/linear_probe_distance_table_top_defines.svh
// Assertion macros shared by the distance table RTL.
`ifndef LINEAR_PROBE_DISTANCE_TABLE_TOP_DEFINES_SVH
`define LINEAR_PROBE_DISTANCE_TABLE_TOP_DEFINES_SVH

// Clocked check, masked while reset is asserted.
`define LPDT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define LPDT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hw/rtl/lpdt_pkg.sv
// Shared constants, codes and control types for the distance table.
package lpdt_pkg;

  // Table geometry
  localparam int SLOTS   = 256;
  localparam int SLOT_AW = $clog2(SLOTS);
  localparam int CNT_W   = SLOT_AW + 1;

  // Field widths
  localparam int FUNC_W = 2;
  localparam int KEY_W  = 16;
  localparam int DIST_W = 32;
  localparam int STAT_W = 2;
  localparam int CFG_W  = 9;
  localparam int MOD_CW = $clog2(KEY_W);

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_UPDATE = 2'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISSING = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_HASH,
    S_MOD,
    S_INS,
    S_PROBE,
    S_CMP
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic              load;
    logic              mod_start;
    logic              probe_init;
    logic              step;
    logic              rd_issue;
    logic              ins_write;
    logic              upd_write;
    logic              res_load;
    logic              res_found;
    logic [STAT_W-1:0] res_status;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              full;
    logic              mod_done;
    logic              probe_at_m;
    logic              probe_at_limit;
    logic              slot_valid;
    logic              key_match;
  } sts_t;

endpackage

FILE: hw/rtl/lpdt_mod.sv
// Bit-serial remainder unit: key modulo the active slot count.
module lpdt_mod
  import lpdt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [KEY_W-1:0]   dividend,
  input  logic [CNT_W-1:0]   divisor,
  output logic               done,
  output logic [SLOT_AW-1:0] remainder
);

  logic [KEY_W-1:0]  sh_r, sh_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [MOD_CW-1:0] cnt_r, cnt_nxt;
  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W:0]    trial;

  // One restoring step per cycle, MSB of the key first
  always_comb begin
    trial    = {rem_r, sh_r[KEY_W-1]};
    sh_nxt   = sh_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      sh_nxt  = dividend;
      rem_nxt = '0;
      cnt_nxt = MOD_CW'(KEY_W - 1);
      run_nxt = 1'b1;
    end else if (run_r) begin
      sh_nxt = {sh_r[KEY_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = CNT_W'(trial - {1'b0, divisor});
      end else begin
        rem_nxt = trial[CNT_W-1:0];
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r  <= sh_nxt;
    rem_r <= rem_nxt;
  end

  // Remainder is below the divisor, so it fits a slot index
  assign done      = done_r;
  assign remainder = rem_r[SLOT_AW-1:0];

endmodule

FILE: hw/rtl/lpdt_dpath.sv
// Datapath: item latch, slot store, probe counters and result register.
module lpdt_dpath
  import lpdt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic [FUNC_W-1:0] in_func,
  input  logic [KEY_W-1:0]  in_vertex_id,
  input  logic [DIST_W-1:0] in_distance,
  input  logic              cfg_we,
  input  logic [CFG_W-1:0]  cfg_wdata,
  output logic              out_valid,
  output logic [STAT_W-1:0] out_status,
  output logic [DIST_W-1:0] out_distance_out
);

`include "linear_probe_distance_table_top_defines.svh"

  logic [FUNC_W-1:0]  func_r;
  logic [KEY_W-1:0]   key_r;
  logic [DIST_W-1:0]  dist_r;
  logic [CFG_W-1:0]   slots_r;
  logic [CNT_W-1:0]   count_r;
  logic [SLOTS-1:0]   valid_r;
  logic [SLOT_AW-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0]   n_r, n_nxt;
  logic [CNT_W-1:0]   m_w;
  logic [CNT_W-1:0]   idx_inc;
  logic [SLOT_AW-1:0] home_idx;
  logic               mod_done;

  logic [KEY_W-1:0]   key_mem_r  [SLOTS];
  logic [DIST_W-1:0]  dist_mem_r [SLOTS];
  logic [KEY_W-1:0]   key_rd_r;
  logic [DIST_W-1:0]  dist_rd_r;

  logic               out_valid_r;
  logic [STAT_W-1:0]  out_status_r;
  logic [DIST_W-1:0]  out_dist_r;

  // Active slot count, clamped to 1..SLOTS
  always_comb begin
    if (slots_r == '0) begin
      m_w = CNT_W'(1);
    end else if (slots_r > CFG_W'(SLOTS)) begin
      m_w = CNT_W'(SLOTS);
    end else begin
      m_w = CNT_W'(slots_r);
    end
  end

  // Config register and item latch
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_r <= CFG_W'(SLOTS);
    end else if (cfg_we) begin
      slots_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      key_r  <= in_vertex_id;
      dist_r <= in_distance;
    end
  end

  // Home slot
  lpdt_mod u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.mod_start),
    .dividend  (key_r),
    .divisor   (m_w),
    .done      (mod_done),
    .remainder (home_idx)
  );

  // Probe index with wrap at the active slot count, and probe counter
  assign idx_inc = CNT_W'({1'b0, idx_r} + 1'b1);

  always_comb begin
    idx_nxt = idx_r;
    n_nxt   = n_r;
    if (cmd.probe_init) begin
      idx_nxt = home_idx;
      n_nxt   = '0;
    end else if (cmd.step) begin
      idx_nxt = (idx_inc >= m_w) ? '0 : idx_inc[SLOT_AW-1:0];
      n_nxt   = n_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    n_r   <= n_nxt;
  end

  // Valid marks and entry count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
    end else if (cmd.ins_write) begin
      valid_r[idx_r] <= 1'b1;
      count_r        <= count_r + 1'b1;
    end
  end

  // Slot store: one write port, one registered read
  always_ff @(posedge clk) begin
    if (cmd.ins_write) begin
      key_mem_r[idx_r] <= key_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ins_write || cmd.upd_write) begin
      dist_mem_r[idx_r] <= dist_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      key_rd_r  <= key_mem_r[idx_r];
      dist_rd_r <= dist_mem_r[idx_r];
    end
  end

  // Status to the controller
  always_comb begin
    sts.func           = func_r;
    sts.full           = (count_r >= m_w);
    sts.mod_done       = mod_done;
    sts.probe_at_m     = (n_r >= m_w);
    sts.probe_at_limit = (n_r >= m_w) || (n_r >= count_r);
    sts.slot_valid     = valid_r[idx_r];
    sts.key_match      = (key_rd_r == key_r);
  end

  // Result register: one-cycle strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.res_load;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_status_r <= cmd.res_status;
      out_dist_r   <= cmd.res_found ? dist_rd_r : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_distance_out = out_dist_r;

  // Checks
  `LPDT_ASSERT(a_count_bound, count_r <= CNT_W'(SLOTS), "entry count beyond slot count")
  `LPDT_ASSERT(a_single_strobe, out_valid_r |=> !out_valid_r, "result strobe held two cycles")

endmodule

FILE: hw/rtl/lpdt_ctrl.sv
// Controller: sequences hashing, probing and result delivery per item.
module lpdt_ctrl
  import lpdt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  sts_t sts,
  output cmd_t cmd
);

`include "linear_probe_distance_table_top_defines.svh"

  state_t state_r, state_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_HASH;
      end
      S_HASH: begin
        if ((sts.func == FUNC_INSERT && !sts.full) ||
            sts.func == FUNC_LOOKUP || sts.func == FUNC_UPDATE) begin
          state_nxt = S_MOD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_MOD: begin
        if (sts.mod_done) begin
          state_nxt = (sts.func == FUNC_INSERT) ? S_INS : S_PROBE;
        end
      end
      S_INS: begin
        if (sts.probe_at_m || !sts.slot_valid) state_nxt = S_IDLE;
      end
      S_PROBE: begin
        if (sts.probe_at_limit || !sts.slot_valid) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        state_nxt = sts.key_match ? S_IDLE : S_PROBE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Command outputs
  always_comb begin
    cmd            = '0;
    cmd.res_status = ST_OK;
    unique case (state_r)
      S_IDLE: begin
        cmd.load = start;
      end
      S_HASH: begin
        if (sts.func == FUNC_INSERT) begin
          if (sts.full) begin
            cmd.res_load   = 1'b1;
            cmd.res_status = ST_FULL;
          end else begin
            cmd.mod_start = 1'b1;
          end
        end else if (sts.func == FUNC_LOOKUP || sts.func == FUNC_UPDATE) begin
          cmd.mod_start = 1'b1;
        end else begin
          // unused operation code
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_MISSING;
        end
      end
      S_MOD: begin
        cmd.probe_init = sts.mod_done;
      end
      S_INS: begin
        if (sts.probe_at_m) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_FULL;
        end else if (!sts.slot_valid) begin
          cmd.ins_write  = 1'b1;
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_OK;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_PROBE: begin
        if (sts.probe_at_limit || !sts.slot_valid) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_MISSING;
        end else begin
          cmd.rd_issue = 1'b1;
        end
      end
      S_CMP: begin
        if (sts.key_match) begin
          cmd.upd_write  = (sts.func == FUNC_UPDATE);
          cmd.res_found  = (sts.func == FUNC_LOOKUP);
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_OK;
        end else begin
          cmd.step = 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  // Checks
  `LPDT_ASSERT(a_ins_free, cmd.ins_write |-> (!sts.slot_valid && !sts.probe_at_m),
               "insert into an occupied slot")
  `LPDT_ASSERT(a_upd_match, cmd.upd_write |-> (sts.key_match && state_r == S_CMP),
               "update without key match")
  `LPDT_ASSERT(a_res_ends, cmd.res_load |=> (state_r == S_IDLE),
               "result issued without returning to idle")
  `LPDT_ASSERT_ALWAYS(a_rst_idle, !rst_n |=> (state_r == S_IDLE), "reset did not idle")

endmodule

FILE: hw/rtl/linear_probe_distance_table_top.sv
// Insert, lookup and update: the item is latched and dispatched, then the bit-serial
// key-modulo unit finds its home slot. Insert steps over occupied slots; lookup and update
// read each slot through the registered slot-store read and compare keys. A full insert
// or unused code answers from dispatch. One item at a time; busy stays high until
// the result strobe, which the receiver takes unconditionally. Reset clears valid marks,
// entry count and the controller at once and sets slots_r to 256; no clearing pass.
module linear_probe_distance_table_top
  import lpdt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [FUNC_W-1:0] in_func,
  input  logic [KEY_W-1:0]  in_vertex_id,
  input  logic [DIST_W-1:0] in_distance,
  input  logic              cfg_we,
  input  logic [CFG_W-1:0]  cfg_wdata,
  output logic              out_valid,
  output logic [STAT_W-1:0] out_status,
  output logic [DIST_W-1:0] out_distance_out
);

  cmd_t cmd;
  sts_t sts;
  logic ctrl_busy;

  // Sequencer
  lpdt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (ctrl_busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // Table storage and arithmetic
  lpdt_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_func          (in_func),
    .in_vertex_id     (in_vertex_id),
    .in_distance      (in_distance),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_distance_out (out_distance_out)
  );

  assign busy = ctrl_busy;

endmodule

FILE: test/linear_probe_distance_table_top_tb.sv
// Self-checking testbench for the linear-probing distance table: random and directed items.
module linear_probe_distance_table_top_tb;
  import lpdt_pkg::*;

  // Unused operation code, answered as not found
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0]  key;
    logic [DIST_W-1:0] dval;
  } table_op_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [DIST_W-1:0] dval;
  } table_answer_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [FUNC_W-1:0] in_func = '0;
  logic [KEY_W-1:0]  in_vertex_id = '0;
  logic [DIST_W-1:0] in_distance = '0;
  logic              cfg_we = 1'b0;
  logic [CFG_W-1:0]  cfg_wdata = '0;
  logic              out_valid;
  logic [STAT_W-1:0] out_status;
  logic [DIST_W-1:0] out_distance_out;
  logic              item_taken;

  // Pending items, expected answers, keys handed to inserts
  table_op_t     op_q[$];
  table_answer_t answer_q[$];
  logic [KEY_W-1:0] known_keys[$];

  // Shadow copy of the table
  logic              tbl_valid[SLOTS];
  logic [KEY_W-1:0]  tbl_key[SLOTS];
  logic [DIST_W-1:0] tbl_dist[SLOTS];
  int unsigned       tbl_count;
  logic [CFG_W-1:0]  slots_cfg;

  int err_count = 0;
  int sender_gap_pct = 6;
  int stall_cycles = 0;

  linear_probe_distance_table_top u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_vertex_id     (in_vertex_id),
    .in_distance      (in_distance),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_distance_out (out_distance_out)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  assign item_taken = rst_n && start && !busy;

  // Register value clamped to 1..SLOTS
  function automatic int unsigned clamp_slots(input logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > SLOTS) return SLOTS;
    return v;
  endfunction

  // Probe from the home slot; -1 on empty slot or probe budget used up
  function automatic int find_entry(input logic [KEY_W-1:0] key, input int unsigned m);
    int unsigned idx;
    idx = key % m;
    for (int unsigned n = 0; n < tbl_count && n < m; n++) begin
      if (!tbl_valid[idx]) return -1;
      if (tbl_key[idx] == key) return idx;
      idx++;
      if (idx >= m) idx = 0;
    end
    return -1;
  endfunction

  // Apply one item to the shadow table and return the answer it should give
  task automatic table_apply(input table_op_t op, output table_answer_t ans);
    int unsigned m;
    int unsigned idx;
    int hit;
    m = clamp_slots(slots_cfg);
    ans.status = ST_MISSING;
    ans.dval = '0;
    case (op.func)
      FUNC_INSERT: begin
        ans.status = ST_FULL;
        if (tbl_count < m) begin
          idx = op.key % m;
          for (int unsigned n = 0; n < m; n++) begin
            if (!tbl_valid[idx]) begin
              tbl_valid[idx] = 1'b1;
              tbl_key[idx] = op.key;
              tbl_dist[idx] = op.dval;
              tbl_count++;
              ans.status = ST_OK;
              break;
            end
            idx++;
            if (idx >= m) idx = 0;
          end
        end
      end
      FUNC_LOOKUP: begin
        hit = find_entry(op.key, m);
        if (hit >= 0) begin
          ans.status = ST_OK;
          ans.dval = tbl_dist[hit];
        end
      end
      FUNC_UPDATE: begin
        hit = find_entry(op.key, m);
        if (hit >= 0) begin
          tbl_dist[hit] = op.dval;
          ans.status = ST_OK;
        end
      end
      default: ;
    endcase
  endtask

  // Driver: hold the item until taken, then maybe present the next one
  always @(posedge clk) begin : drive_items
    table_op_t     op;
    table_answer_t ans;
    if (rst_n) begin
      if (item_taken) begin
        table_apply('{func: in_func, key: in_vertex_id, dval: in_distance}, ans);
        answer_q.push_back(ans);
      end
      if (!start || item_taken) begin
        if (op_q.size() > 0 && $urandom_range(99) >= sender_gap_pct) begin
          op = op_q.pop_front();
          start <= 1'b1;
          in_func <= op.func;
          in_vertex_id <= op.key;
          in_distance <= op.dval;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed result against the oldest expected answer
  always @(posedge clk) begin : check_answers
    table_answer_t exp_ans;
    if (rst_n && out_valid) begin
      if (answer_q.size() == 0) begin
        $display("%0t: unexpected result status=%0d distance=%h", $time, out_status,
                 out_distance_out);
        err_count++;
      end else begin
        exp_ans = answer_q.pop_front();
        if (out_status !== exp_ans.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_ans.status, out_status);
          err_count++;
        end
        if (out_distance_out !== exp_ans.dval) begin
          $display("%0t: distance expected %h actual %h", $time, exp_ans.dval,
                   out_distance_out);
          err_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no item in or result out
  always @(posedge clk) begin
    if (!rst_n || item_taken || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic write_slots(input logic [CFG_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    slots_cfg = v;
  endtask

  task automatic add_op(input logic [FUNC_W-1:0] f, input logic [KEY_W-1:0] k,
                        input logic [DIST_W-1:0] d);
    op_q.push_back('{func: f, key: k, dval: d});
  endtask

  // Wait until every item is taken and answered, plus a short settle
  task automatic drain();
    while (op_q.size() != 0 || start || answer_q.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Key source: known keys, keys colliding on a few home slots, or any key
  function automatic logic [KEY_W-1:0] pick_key(input int unsigned m);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45 && known_keys.size() > 0)
      return known_keys[$urandom_range(known_keys.size() - 1)];
    if (r < 80)
      return KEY_W'($urandom_range(3) + m * $urandom_range(255));
    return KEY_W'($urandom);
  endfunction

  function automatic logic [DIST_W-1:0] pick_dist();
    int unsigned r;
    r = $urandom_range(19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  task automatic gen_phase(input int count, input int unsigned m, input int ins_pct);
    int unsigned r;
    logic [KEY_W-1:0] k;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      k = pick_key(m);
      if (r < ins_pct) begin
        known_keys.push_back(k);
        add_op(FUNC_INSERT, k, pick_dist());
      end else if (r < ins_pct + (100 - ins_pct) * 6 / 10) begin
        add_op(FUNC_LOOKUP, k, pick_dist());
      end else if (r < 96) begin
        add_op(FUNC_UPDATE, k, pick_dist());
      end else begin
        add_op(FUNC_UNUSED, k, pick_dist());
      end
    end
  endtask

  initial begin : stimulus
    int unsigned cfg_plan[10];
    int          ins_plan[10];
    cfg_plan = '{7, 16, 0, 1, 2, 64, 511, 300, 3, 256};
    ins_plan = '{40, 40, 30, 30, 30, 45, 45, 45, 30, 65};
    for (int i = 0; i < SLOTS; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_key[i] = '0;
      tbl_dist[i] = '0;
    end
    tbl_count = 0;
    slots_cfg = CFG_W'(SLOTS);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty table, extremes, duplicates, wrap-around, unused code
    write_slots(CFG_W'(SLOTS));
    add_op(FUNC_LOOKUP, 16'd0, 32'd0);
    add_op(FUNC_UPDATE, 16'd0, 32'hFFFF_FFFF);
    add_op(FUNC_INSERT, 16'd0, 32'd0);
    add_op(FUNC_INSERT, 16'hFFFF, 32'hFFFF_FFFF);
    add_op(FUNC_LOOKUP, 16'd0, 32'd0);
    add_op(FUNC_LOOKUP, 16'hFFFF, 32'd0);
    add_op(FUNC_INSERT, 16'd0, 32'h1234_5678);
    add_op(FUNC_LOOKUP, 16'd0, 32'd0);
    add_op(FUNC_UPDATE, 16'd0, 32'hA5A5_A5A5);
    add_op(FUNC_LOOKUP, 16'd0, 32'd0);
    add_op(FUNC_INSERT, 16'd511, 32'h0001_0000);
    add_op(FUNC_LOOKUP, 16'd511, 32'd0);
    add_op(FUNC_LOOKUP, 16'd256, 32'd0);
    add_op(FUNC_UPDATE, 16'hFFFF, 32'h5A5A_5A5A);
    add_op(FUNC_LOOKUP, 16'hFFFF, 32'd0);
    add_op(FUNC_UNUSED, 16'd0, 32'hFFFF_FFFF);
    add_op(FUNC_LOOKUP, 16'd1, 32'd0);
    drain();

    // Zero register acts as one slot; entries beyond it are not probed
    write_slots('0);
    add_op(FUNC_INSERT, 16'd5, 32'd5);
    add_op(FUNC_LOOKUP, 16'd0, 32'd0);
    add_op(FUNC_LOOKUP, 16'hFFFF, 32'd0);
    add_op(FUNC_UPDATE, 16'd0, 32'd7);
    drain();

    // Register above the table size acts as the full table
    write_slots('1);
    add_op(FUNC_LOOKUP, 16'hFFFF, 32'd0);
    add_op(FUNC_LOOKUP, 16'd0, 32'd0);
    drain();

    // Random phases over several table sizes and sender gap rates
    for (int p = 0; p < 10; p++) begin
      write_slots(CFG_W'(cfg_plan[p]));
      sender_gap_pct = (p < 4) ? 6 : ((p < 7) ? 53 : 0);
      gen_phase(153, clamp_slots(CFG_W'(cfg_plan[p])), ins_plan[p]);
      drain();
    end

    repeat (30) @(posedge clk);
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
